>>> hdl/fbh_pkg.sv
// Shared types and constants for the filename bucket hash.
package fbh_pkg;

   localparam int CHAR_W   = 8;
   localparam int HASH_W   = 32;
   localparam int BUCKET_W = 31;
   localparam int LOG2_W   = 5;

   localparam logic [HASH_W-1:0] HASH_SEED  = 32'h1234_5678;
   localparam logic [HASH_W-1:0] POS_OFFSET = 32'd119;
   localparam int FOLD_SHIFT_LO = 10;
   localparam int FOLD_SHIFT_HI = 20;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_CASE_BIT = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_DOT      = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_BSLASH   = 8'h5C;
   localparam logic [CHAR_W-1:0] CHAR_SLASH    = 8'h2F;

   localparam logic [LOG2_W-1:0] TABLE_LOG2_RESET = 5'd10;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              accumulate;
      logic              last;
   } entry_type;

endpackage

>>> hdl/filename_bucket_hash_core.sv
// Top level of the filename bucket hash: control register, front end, queue and back end.
//
// A name is written one byte per word, with end_of_name set on its final byte; the bucket
// for that name passes from the queue slot through the product register into the output
// register. The block takes one byte every cycle while full is low: the front end
// classifies each byte as it arrives, a short queue of QUEUE_DEPTH words holds classified
// bytes, and the back end runs a two-stage pipeline of one 8 by 32 bit multiply followed
// by the 32-bit accumulate and fold. A result passes through a single output register, so
// the next name is accepted while a bucket still waits; only when the final byte of a
// further name is held behind that waiting bucket and the queue has filled behind it does
// full rise. The table size is held in one control register, which the user must write
// only while the block is idle; the block itself does not enforce this.
module filename_bucket_hash_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_name_byte,
   input  logic        req_end_of_name,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [30:0] rsp_bucket,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   logic [fbh_pkg::LOG2_W-1:0] table_log2_ff, table_log2_in;
   logic                       q_push, q_pop, q_empty;
   fbh_pkg::entry_type         push_entry, pop_entry;

   assign csr_ready     = 1'b1;
   assign table_log2_in = (csr_valid & csr_ready) ? csr_data : table_log2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_log2_ff <= fbh_pkg::TABLE_LOG2_RESET;
      end else begin
         table_log2_ff <= table_log2_in;
      end
   end

   fbh_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_name_byte   (req_name_byte),
      .req_end_of_name (req_end_of_name),
      .q_push          (q_push),
      .q_entry         (push_entry)
   );

   fbh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (req_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   fbh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .table_log2 (table_log2_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_bucket (rsp_bucket)
   );

endmodule

>>> hdl/fbh_front.sv
// Front end: normalises each name byte and tracks the stop condition.
module fbh_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic                req_full,
   input  logic [7:0]          req_name_byte,
   input  logic                req_end_of_name,
   output logic                q_push,
   output fbh_pkg::entry_type  q_entry
);

   logic                        stopped_ff;
   logic                        stopped_in;
   logic                        accepted;
   logic                        is_stop;
   logic [fbh_pkg::CHAR_W-1:0]  lowered;

   assign accepted = req_push & ~req_full;

   always_comb begin
      lowered = req_name_byte;
      if (req_name_byte >= fbh_pkg::CHAR_UPPER_A && req_name_byte <= fbh_pkg::CHAR_UPPER_Z) begin
         lowered = req_name_byte | fbh_pkg::CHAR_CASE_BIT;
      end
      is_stop = (lowered == fbh_pkg::CHAR_DOT) || (lowered == fbh_pkg::CHAR_NUL);
   end

   always_comb begin
      q_entry.char_code  = (lowered == fbh_pkg::CHAR_BSLASH) ? fbh_pkg::CHAR_SLASH : lowered;
      q_entry.accumulate = ~stopped_ff & ~is_stop;
      q_entry.last       = req_end_of_name;
   end

   assign q_push = accepted;

   always_comb begin
      stopped_in = stopped_ff;
      if (accepted) begin
         stopped_in = req_end_of_name ? 1'b0 : (stopped_ff | is_stop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= 1'b0;
      end else begin
         stopped_ff <= stopped_in;
      end
   end

endmodule

>>> hdl/fbh_queue.sv
// Small first-in first-out queue of classified words between front and back.
module fbh_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fbh_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output fbh_pkg::entry_type  pop_entry,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   fbh_pkg::entry_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/fbh_back.sv
// Back end: weighted multiply, accumulation, folding and the result register.
module fbh_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  fbh_pkg::entry_type           q_entry,
   output logic                         q_pop,
   input  logic [fbh_pkg::LOG2_W-1:0]   table_log2,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [30:0]                  rsp_bucket
);

   localparam logic [fbh_pkg::BUCKET_W-1:0] MASK_ALL = '1;
   localparam logic [fbh_pkg::LOG2_W-1:0]   MAX_LOG2 = fbh_pkg::LOG2_W'(fbh_pkg::BUCKET_W);

   logic                          a_valid_ff, a_valid_in;
   logic                          a_accumulate_ff;
   logic                          a_last_ff;
   logic [fbh_pkg::HASH_W-1:0]    a_product_ff, a_product_in;
   logic [fbh_pkg::HASH_W-1:0]    pos_ff, pos_in;
   logic [fbh_pkg::HASH_W-1:0]    acc_ff, acc_in;
   logic                          out_valid_ff, out_valid_in;
   logic [fbh_pkg::BUCKET_W-1:0]  out_bucket_ff, out_bucket_in;
   logic [fbh_pkg::HASH_W-1:0]    char_ext;
   logic [fbh_pkg::HASH_W-1:0]    acc_sum;
   logic [fbh_pkg::HASH_W-1:0]    folded;
   logic [fbh_pkg::BUCKET_W-1:0]  bucket_mask;
   logic                          advance;
   logic                          retire;

   assign advance = ~(a_valid_ff & a_last_ff & out_valid_ff & ~rsp_pop);
   assign q_pop   = ~q_empty & advance;
   assign retire  = a_valid_ff & advance;

   assign char_ext     = {{(fbh_pkg::HASH_W - fbh_pkg::CHAR_W){q_entry.char_code[fbh_pkg::CHAR_W-1]}},
                          q_entry.char_code};
   assign a_product_in = char_ext * (pos_ff + fbh_pkg::POS_OFFSET);
   assign a_valid_in   = advance ? ~q_empty : a_valid_ff;

   always_comb begin
      pos_in = pos_ff;
      if (q_pop) begin
         if (q_entry.last) begin
            pos_in = '0;
         end else if (q_entry.accumulate) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      acc_sum     = a_accumulate_ff ? acc_ff + a_product_ff : acc_ff;
      folded      = acc_sum ^ (acc_sum >> fbh_pkg::FOLD_SHIFT_LO) ^ (acc_sum >> fbh_pkg::FOLD_SHIFT_HI);
      bucket_mask = MASK_ALL >> (MAX_LOG2 - table_log2);
      acc_in        = acc_ff;
      out_bucket_in = out_bucket_ff;
      if (retire) begin
         acc_in = a_last_ff ? fbh_pkg::HASH_SEED : acc_sum;
         if (a_last_ff) begin
            out_bucket_in = folded[fbh_pkg::BUCKET_W-1:0] & bucket_mask;
         end
      end
      out_valid_in = (out_valid_ff & ~rsp_pop) | (retire & a_last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         pos_ff       <= '0;
         acc_ff       <= fbh_pkg::HASH_SEED;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_product_ff    <= a_product_in;
         a_accumulate_ff <= q_entry.accumulate;
         a_last_ff       <= q_entry.last;
      end
      out_bucket_ff <= out_bucket_in;
   end

   assign rsp_empty  = ~out_valid_ff;
   assign rsp_bucket = out_bucket_ff;

endmodule

>>> test/tb_top.sv
// Testbench for the filename bucket hash core: directed and random names checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int HALF_PERIOD  = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_ITEMS = 400;
   localparam int PHASES       = 5;

   logic                         clock           = 1'b0;
   logic                         reset           = 1'b1;
   logic                         req_push        = 1'b0;
   logic                         req_full;
   logic [fbh_pkg::CHAR_W-1:0]   req_name_byte   = '0;
   logic                         req_end_of_name = 1'b0;
   logic                         rsp_empty;
   logic                         rsp_pop         = 1'b0;
   logic [fbh_pkg::BUCKET_W-1:0] rsp_bucket;
   logic                         csr_valid       = 1'b0;
   logic                         csr_ready;
   logic [fbh_pkg::LOG2_W-1:0]   csr_data        = '0;

   logic [fbh_pkg::HASH_W-1:0]   name_sum     = fbh_pkg::HASH_SEED;
   logic [fbh_pkg::HASH_W-1:0]   name_pos     = '0;
   logic                         name_stopped = 1'b0;
   logic [fbh_pkg::LOG2_W-1:0]   table_log2   = fbh_pkg::TABLE_LOG2_RESET;

   logic [fbh_pkg::BUCKET_W-1:0] bucket_queue[$];
   logic [fbh_pkg::BUCKET_W-1:0] expected_bucket;
   int                           fail_count  = 0;
   int                           items_sent  = 0;
   int                           cycle_count = 0;
   int                           pop_stall   = 0;
   bit                           idling_on   = 1'b1;

   filename_bucket_hash_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_name_byte   (req_name_byte),
      .req_end_of_name (req_end_of_name),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_bucket      (rsp_bucket),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what,
                                  input logic [fbh_pkg::BUCKET_W-1:0] got,
                                  input logic [fbh_pkg::BUCKET_W-1:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at cycle %0d", what, got, want, cycle_count);
      fail_count++;
   endtask

   // Folds one accepted byte into the predicted name hash; a final byte yields a bucket.
   task automatic hash_name_byte(input logic [fbh_pkg::CHAR_W-1:0] raw, input logic last);
      logic [fbh_pkg::CHAR_W-1:0] ch;
      logic [fbh_pkg::HASH_W-1:0] folded;
      logic [fbh_pkg::HASH_W-1:0] mask;
      ch = raw;
      if (!name_stopped) begin
         if (ch >= fbh_pkg::CHAR_UPPER_A && ch <= fbh_pkg::CHAR_UPPER_Z)
            ch = ch + fbh_pkg::CHAR_CASE_BIT;
         if (ch == fbh_pkg::CHAR_DOT || ch == fbh_pkg::CHAR_NUL) begin
            name_stopped = 1'b1;
         end else begin
            if (ch == fbh_pkg::CHAR_BSLASH)
               ch = fbh_pkg::CHAR_SLASH;
            name_sum = name_sum
                       + {{(fbh_pkg::HASH_W-fbh_pkg::CHAR_W){ch[fbh_pkg::CHAR_W-1]}}, ch}
                       * (name_pos + fbh_pkg::POS_OFFSET);
            name_pos = name_pos + 1;
         end
      end
      if (last) begin
         folded = name_sum ^ (name_sum >> fbh_pkg::FOLD_SHIFT_LO)
                  ^ (name_sum >> fbh_pkg::FOLD_SHIFT_HI);
         mask   = (32'd1 << table_log2) - 32'd1;
         bucket_queue.push_back(fbh_pkg::BUCKET_W'(folded & mask));
         name_sum     = fbh_pkg::HASH_SEED;
         name_pos     = '0;
         name_stopped = 1'b0;
      end
   endtask

   task automatic push_byte(input logic [fbh_pkg::CHAR_W-1:0] value, input logic last);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_name_byte   <= value;
      req_end_of_name <= last;
      do
         @(posedge clock);
      while (req_full);
      hash_name_byte(value, last);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (bucket_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_table_log2(input logic [fbh_pkg::LOG2_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid  <= 1'b0;
      table_log2 = value;
   endtask

   function automatic logic [fbh_pkg::CHAR_W-1:0] random_name_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         return fbh_pkg::CHAR_W'(8'h61 + $urandom_range(0, 25));
      else if (pick < 60)
         return fbh_pkg::CHAR_W'(fbh_pkg::CHAR_UPPER_A + $urandom_range(0, 25));
      else if (pick < 70)
         return fbh_pkg::CHAR_W'(8'h30 + $urandom_range(0, 9));
      else if (pick < 75)
         return fbh_pkg::CHAR_SLASH;
      else if (pick < 80)
         return fbh_pkg::CHAR_BSLASH;
      else if (pick < 90)
         return fbh_pkg::CHAR_W'(8'h80 + $urandom_range(0, 127));
      else if (pick < 96)
         return fbh_pkg::CHAR_W'($urandom_range(0, 255));
      else if (pick < 98)
         return fbh_pkg::CHAR_DOT;
      else
         return fbh_pkg::CHAR_NUL;
   endfunction

   task automatic send_random_name();
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
         push_byte(random_name_char(), i == len - 1);
   endtask

   task automatic test_directed_bytes();
      push_byte(fbh_pkg::CHAR_UPPER_A, 1'b1);
      push_byte(fbh_pkg::CHAR_UPPER_Z, 1'b0);
      push_byte(8'h40, 1'b0);
      push_byte(8'h5B, 1'b0);
      push_byte(8'h60, 1'b0);
      push_byte(8'h7B, 1'b1);
      push_byte(fbh_pkg::CHAR_BSLASH, 1'b0);
      push_byte(fbh_pkg::CHAR_SLASH, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h61, 1'b0);
      push_byte(fbh_pkg::CHAR_DOT, 1'b0);
      push_byte(8'h62, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(fbh_pkg::CHAR_NUL, 1'b1);
      push_byte(8'h63, 1'b0);
      push_byte(fbh_pkg::CHAR_DOT, 1'b1);
      push_byte(8'h64, 1'b0);
      push_byte(fbh_pkg::CHAR_NUL, 1'b0);
      push_byte(fbh_pkg::CHAR_UPPER_A, 1'b1);
      push_byte(8'h01, 1'b1);
      push_byte(8'hFE, 1'b1);
   endtask

   task automatic test_table_sizes();
      write_table_log2(5'd0);
      repeat (4) send_random_name();
      write_table_log2(5'd31);
      repeat (4) send_random_name();
      write_table_log2(5'd1);
      repeat (3) send_random_name();
      write_table_log2(5'd21);
      repeat (3) send_random_name();
   endtask

   task automatic test_random_names();
      int start;
      for (int phase = 0; phase < PHASES - 1; phase++) begin
         write_table_log2(fbh_pkg::LOG2_W'($urandom_range(0, 31)));
         start = items_sent;
         while (items_sent - start < RANDOM_ITEMS / PHASES)
            send_random_name();
      end
   endtask

   task automatic test_full_rate();
      int start;
      write_table_log2(5'd31);
      idling_on = 1'b0;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS / PHASES)
         send_random_name();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop   <= 1'b0;
         pop_stall = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (bucket_queue.size() == 0) begin
               report_mismatch("unexpected bucket", rsp_bucket, '0);
            end else begin
               expected_bucket = bucket_queue.pop_front();
               if (rsp_bucket !== expected_bucket)
                  report_mismatch("bucket", rsp_bucket, expected_bucket);
            end
         end
         if (pop_stall > 0) begin
            pop_stall--;
            rsp_pop <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            pop_stall = $urandom_range(1, 19) - 1;
            rsp_pop   <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_bytes();
      test_table_sizes();
      test_random_names();
      test_full_rate();
      wait_idle();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
